[design/assert_macros.svh]
// assertion macros shared by the scoped register file modules
// no dependencies; take in with a bare include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SRFU_ASSERT(lbl, clk, rst_n, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property must never hold outside reset
`define SRFU_NEVER(lbl, clk, rst_n, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

[design/srfu_pkg.sv]
// types and codes for the scoped register file with undo
// no dependencies
`timescale 1ns / 1ps

package srfu_pkg;

	localparam int NUM_BANKS = 3;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_OPEN  = 2'd2;
	localparam logic [1:0] OP_CLOSE = 2'd3;

	localparam logic [1:0] BANK_COUNT = 2'd0;
	localparam logic [1:0] BANK_DIM   = 2'd1;
	localparam logic [1:0] BANK_GLUE  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SCOPE   = 2'd1;
	localparam logic [1:0] ST_UNDO_FULL  = 2'd2;
	localparam logic [1:0] ST_SCOPE_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [1:0]         bank;
		logic [7:0]         reg_index;
		logic signed [31:0] write_value;
		logic               is_global;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic [1:0]  bank;
		logic [7:0]  index;
		logic [31:0] old;
	} undo_entry_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
		logic undo;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic close_open;
		logic undo_done;
	} sts_t;

endpackage

[design/srfu_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module srfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/srfu_datapath.sv]
// datapath: register banks, undo stack, scope marks and their pointers
// depends on srfu_pkg, srfu_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfu_datapath #(
	parameter int REGS_PER_BANK = 256,
	parameter int UNDO_DEPTH    = 1024,
	parameter int SCOPE_DEPTH   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srfu_pkg::ctl_t   ctl,
	output srfu_pkg::sts_t   sts,
	input  srfu_pkg::cmd_t   cmd,
	output srfu_pkg::result_t result
);

	localparam int BANK_WORDS = srfu_pkg::NUM_BANKS * REGS_PER_BANK;
	localparam int BA_W = $clog2(BANK_WORDS);
	localparam int UT_W = $clog2(UNDO_DEPTH + 1);
	localparam int UA_W = $clog2(UNDO_DEPTH);
	localparam int ST_W = $clog2(SCOPE_DEPTH + 1);
	localparam int SA_W = $clog2(SCOPE_DEPTH);
	localparam int UE_W = $bits(srfu_pkg::undo_entry_t);
	localparam logic [BA_W-1:0] BASE_DIM  = BA_W'(REGS_PER_BANK);
	localparam logic [BA_W-1:0] BASE_GLUE = BA_W'(2 * REGS_PER_BANK);
	localparam logic [BA_W-1:0] CLR_LAST  = BA_W'(BANK_WORDS - 1);

	function automatic logic [BA_W-1:0] slot_addr(input logic [1:0] b, input logic [7:0] idx);
		logic [BA_W-1:0] base;
		case (b)
			srfu_pkg::BANK_DIM:  base = BASE_DIM;
			srfu_pkg::BANK_GLUE: base = BASE_GLUE;
			default:             base = '0;
		endcase
		return base + BA_W'(idx);
	endfunction

	function automatic logic slot_ok(input logic [1:0] b, input logic [7:0] idx);
		return (int'(b) < srfu_pkg::NUM_BANKS) && (int'(idx) < REGS_PER_BANK);
	endfunction

	srfu_pkg::cmd_t      cmd_q;
	srfu_pkg::result_t   result_q;
	srfu_pkg::undo_entry_t entry;
	logic [BA_W-1:0]     clr_q;
	logic [UT_W-1:0]     undo_top_q, undo_top_dec, mark_q;
	logic [ST_W-1:0]     scope_top_q, scope_top_dec;
	logic                pend_s1;

	logic                bank_we;
	logic [BA_W-1:0]     bank_waddr, bank_raddr;
	logic [31:0]         bank_wdata, bank_rdata;
	logic [UE_W-1:0]     undo_rdata;
	logic [UT_W-1:0]     scope_rdata;

	logic cur_ok, logs, undo_full, scope_full, is_write, push, wr_reg;
	logic open_ok, close_ok, pop, undo_left;
	logic [1:0] status_d;

	assign undo_top_dec  = undo_top_q - UT_W'(1);
	assign scope_top_dec = scope_top_q - ST_W'(1);
	assign entry         = srfu_pkg::undo_entry_t'(undo_rdata);

	assign cur_ok     = slot_ok(cmd_q.bank, cmd_q.reg_index);
	assign logs       = !cmd_q.is_global && (scope_top_q != '0);
	assign undo_full  = undo_top_q >= UT_W'(UNDO_DEPTH);
	assign scope_full = scope_top_q >= ST_W'(SCOPE_DEPTH);
	assign is_write   = ctl.exec && (cmd_q.op == srfu_pkg::OP_WRITE) && cur_ok;
	assign push       = is_write && logs && !undo_full;
	assign wr_reg     = is_write && !(logs && undo_full);
	assign open_ok    = ctl.exec && (cmd_q.op == srfu_pkg::OP_OPEN) && !scope_full;
	assign close_ok   = ctl.exec && (cmd_q.op == srfu_pkg::OP_CLOSE) && (scope_top_q != '0);
	assign undo_left  = undo_top_q > mark_q;
	assign pop        = ctl.undo && undo_left;

	always_comb begin
		case (cmd_q.op)
			srfu_pkg::OP_WRITE:
				status_d = (cur_ok && logs && undo_full) ? srfu_pkg::ST_UNDO_FULL
				                                         : srfu_pkg::ST_OK;
			srfu_pkg::OP_OPEN:
				status_d = scope_full ? srfu_pkg::ST_SCOPE_FULL : srfu_pkg::ST_OK;
			srfu_pkg::OP_CLOSE:
				status_d = (scope_top_q == '0) ? srfu_pkg::ST_NO_SCOPE : srfu_pkg::ST_OK;
			default:
				status_d = srfu_pkg::ST_OK;
		endcase
	end

	// bank port: clearing sweep, restore from undo, or a plain write
	always_comb begin
		bank_raddr = slot_addr(cmd.bank, cmd.reg_index);
		if (ctl.clear) begin
			bank_we    = 1'b1;
			bank_waddr = clr_q;
			bank_wdata = '0;
		end else if (ctl.undo) begin
			bank_we    = pend_s1;
			bank_waddr = slot_addr(entry.bank, entry.index);
			bank_wdata = entry.old;
		end else begin
			bank_we    = wr_reg;
			bank_waddr = slot_addr(cmd_q.bank, cmd_q.reg_index);
			bank_wdata = cmd_q.write_value;
		end
	end

	srfu_ram #(.WIDTH(32), .DEPTH(BANK_WORDS)) u_bank_ram (
		.clk   (clk),
		.we    (bank_we),
		.waddr (bank_waddr),
		.wdata (bank_wdata),
		.raddr (bank_raddr),
		.rdata (bank_rdata)
	);

	srfu_ram #(.WIDTH(UE_W), .DEPTH(UNDO_DEPTH)) u_undo_ram (
		.clk   (clk),
		.we    (push),
		.waddr (undo_top_q[UA_W-1:0]),
		.wdata (UE_W'({cmd_q.bank, cmd_q.reg_index, bank_rdata})),
		.raddr (undo_top_dec[UA_W-1:0]),
		.rdata (undo_rdata)
	);

	srfu_ram #(.WIDTH(UT_W), .DEPTH(SCOPE_DEPTH)) u_scope_ram (
		.clk   (clk),
		.we    (open_ok),
		.waddr (scope_top_q[SA_W-1:0]),
		.wdata (undo_top_q),
		.raddr (scope_top_dec[SA_W-1:0]),
		.rdata (scope_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			undo_top_q  <= '0;
			scope_top_q <= '0;
			pend_s1     <= 1'b0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + BA_W'(1);
			end
			if (push) begin
				undo_top_q <= undo_top_q + UT_W'(1);
			end else if (pop) begin
				undo_top_q <= undo_top_dec;
			end
			if (open_ok) begin
				scope_top_q <= scope_top_q + ST_W'(1);
			end else if (close_ok) begin
				scope_top_q <= scope_top_dec;
			end
			// entry read this cycle is restored in the next
			pend_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd;
		end
		if (close_ok) begin
			mark_q <= scope_rdata;
		end
		if (ctl.exec) begin
			result_q.status     <= status_d;
			result_q.read_value <= ((cmd_q.op == srfu_pkg::OP_READ) && cur_ok)
			                       ? $signed(bank_rdata) : '0;
		end
	end

	assign sts.clr_last   = clr_q == CLR_LAST;
	assign sts.close_open = (cmd_q.op == srfu_pkg::OP_CLOSE) && (scope_top_q != '0);
	assign sts.undo_done  = !undo_left && !pend_s1;
	assign result         = result_q;

	`SRFU_ASSERT(a_undo_top, clk, arst_n, undo_top_q <= UT_W'(UNDO_DEPTH), "undo top too big")
	`SRFU_ASSERT(a_scope_top, clk, arst_n, scope_top_q <= ST_W'(SCOPE_DEPTH), "scope top too big")
	`SRFU_ASSERT(a_pend_after_pop, clk, arst_n, pend_s1 |-> $past(ctl.undo), "restore without pop")
	`SRFU_NEVER(a_push_and_pop, clk, arst_n, push && pop, "push and pop together")

endmodule

[design/srfu_ctrl.sv]
// controller: clearing sweep, accept, execute and undo walk sequencing
// depends on srfu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output srfu_pkg::ctl_t ctl,
	input  srfu_pkg::sts_t sts
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_UNDO  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.close_open) begin
					state_d = S_UNDO;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_UNDO: begin
				if (sts.undo_done) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign ctl.clear  = state_q == S_CLEAR;
	assign ctl.accept = (state_q == S_IDLE) && start;
	assign ctl.exec   = state_q == S_EXEC;
	assign ctl.undo   = state_q == S_UNDO;
	assign busy       = state_q != S_IDLE;
	assign done       = done_q;

	`SRFU_ASSERT(a_accept_exec, clk, arst_n, ctl.accept |=> ctl.exec, "accept did not execute")
	`SRFU_ASSERT(a_done_source, clk, arst_n, done |-> $past(ctl.exec || ctl.undo), "word without work")
	`SRFU_NEVER(a_done_busy, clk, arst_n, done && busy, "word while busy")

endmodule

[design/scoped_register_file_with_undo.sv]
// top level of the scoped register file with undo: three banks, undo stack, scope marks
// depends on srfu_pkg, srfu_ctrl, srfu_datapath
// read, write and open: accepted from idle, executed in the exec state, word registered with done
// close of an open scope: after exec, the undo state restores each entry down to the scope mark
// a new command is taken only in idle, so commands are handled one at a time
// reset: busy while the banks are swept to zero
`timescale 1ns / 1ps

module scoped_register_file_with_undo #(
	parameter int REGS_PER_BANK = 256,
	parameter int UNDO_DEPTH    = 1024,
	parameter int SCOPE_DEPTH   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srfu_pkg::cmd_t    cmd,
	output logic              done,
	output srfu_pkg::result_t result
);

	srfu_pkg::ctl_t ctl;
	srfu_pkg::sts_t sts;

	srfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	srfu_datapath #(
		.REGS_PER_BANK (REGS_PER_BANK),
		.UNDO_DEPTH    (UNDO_DEPTH),
		.SCOPE_DEPTH   (SCOPE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.cmd    (cmd),
		.result (result)
	);

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the scoped register file with undo: directed words, then random phases
// depends on srfu_pkg and scoped_register_file_with_undo; holds its own prediction of the banks

module tb_top;

	localparam int REGS_PER_BANK = 256;
	localparam int UNDO_DEPTH    = 1024;
	localparam int SCOPE_DEPTH   = 64;
	localparam logic [1:0] BANK_NONE = 2'd3;
	localparam int STALL_LIMIT = 4 * (srfu_pkg::NUM_BANKS * REGS_PER_BANK + UNDO_DEPTH + 100);
	localparam int END_CYCLES  = 32;

	class undo_file_model;
		logic [31:0]           regs [srfu_pkg::NUM_BANKS][REGS_PER_BANK];
		srfu_pkg::undo_entry_t undo_log [UNDO_DEPTH];
		int                    marks [SCOPE_DEPTH];
		int                    undo_top;
		int                    scope_top;
		srfu_pkg::result_t     pending_results [$];
		int                    errors;

		function new();
			foreach (regs[b, i]) regs[b][i] = '0;
			undo_top  = 0;
			scope_top = 0;
			errors    = 0;
		endfunction

		function bit slot_ok(logic [1:0] bank, logic [7:0] idx);
			return bank < srfu_pkg::NUM_BANKS && idx < REGS_PER_BANK;
		endfunction

		// predict the word caused by one accepted command and update the banks
		function void note_cmd(srfu_pkg::cmd_t c);
			srfu_pkg::result_t     r;
			srfu_pkg::undo_entry_t e;
			r.read_value = '0;
			r.status     = srfu_pkg::ST_OK;
			case (c.op)
				srfu_pkg::OP_READ: begin
					if (slot_ok(c.bank, c.reg_index))
						r.read_value = regs[c.bank][c.reg_index];
				end
				srfu_pkg::OP_WRITE: begin
					if (slot_ok(c.bank, c.reg_index)) begin
						if (!c.is_global && scope_top != 0) begin
							if (undo_top >= UNDO_DEPTH) begin
								r.status = srfu_pkg::ST_UNDO_FULL;
							end else begin
								e.bank  = c.bank;
								e.index = c.reg_index;
								e.old   = regs[c.bank][c.reg_index];
								undo_log[undo_top] = e;
								undo_top++;
							end
						end
						if (r.status == srfu_pkg::ST_OK)
							regs[c.bank][c.reg_index] = c.write_value;
					end
				end
				srfu_pkg::OP_OPEN: begin
					if (scope_top >= SCOPE_DEPTH) begin
						r.status = srfu_pkg::ST_SCOPE_FULL;
					end else begin
						marks[scope_top] = undo_top;
						scope_top++;
					end
				end
				default: begin
					if (scope_top == 0) begin
						r.status = srfu_pkg::ST_NO_SCOPE;
					end else begin
						scope_top--;
						while (undo_top > marks[scope_top]) begin
							undo_top--;
							e = undo_log[undo_top];
							if (slot_ok(e.bank, e.index))
								regs[e.bank][e.index] = e.old;
						end
					end
				end
			endcase
			pending_results = {pending_results, r};
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(srfu_pkg::result_t got);
			srfu_pkg::result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("word with none expected");
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value)
					report_mismatch($sformatf("read_value %h, expected %h",
						got.read_value, want.read_value));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	srfu_pkg::cmd_t    cmd = '0;
	logic              done;
	srfu_pkg::result_t result;

	undo_file_model sb = new();
	int send_idle_pct = 16;
	int stall_cycles = 0;

	scoped_register_file_with_undo #(
		.REGS_PER_BANK(REGS_PER_BANK),
		.UNDO_DEPTH(UNDO_DEPTH),
		.SCOPE_DEPTH(SCOPE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word(result);
	end

	// ends the run when neither side moves a word for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic srfu_pkg::cmd_t make_cmd(logic [1:0] op, logic [1:0] bank,
			logic [7:0] idx, logic [31:0] val, logic glob);
		srfu_pkg::cmd_t c;
		c.op          = op;
		c.bank        = bank;
		c.reg_index   = idx;
		c.write_value = val;
		c.is_global   = glob;
		return c;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic srfu_pkg::cmd_t rand_cmd();
		srfu_pkg::cmd_t c;
		int             pick;
		pick = $urandom_range(99);
		if (pick < 30)      c.op = srfu_pkg::OP_READ;
		else if (pick < 68) c.op = srfu_pkg::OP_WRITE;
		else if (pick < 85) c.op = srfu_pkg::OP_OPEN;
		else                c.op = srfu_pkg::OP_CLOSE;
		c.bank = ($urandom_range(9) == 0) ? BANK_NONE
		                                  : 2'($urandom_range(srfu_pkg::NUM_BANKS - 1));
		// a few hot slots so reads and restores hit written registers
		c.reg_index   = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
		c.write_value = rand_value();
		c.is_global   = ($urandom_range(3) == 0);
		return c;
	endfunction

	function automatic srfu_pkg::cmd_t local_write();
		return make_cmd(srfu_pkg::OP_WRITE, 2'($urandom_range(srfu_pkg::NUM_BANKS - 1)),
			8'($urandom_range(255)), rand_value(), 1'b0);
	endfunction

	task automatic send_cmd(input srfu_pkg::cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic send_mixed(input int count);
		repeat (count) send_cmd(rand_cmd());
	endtask

	task automatic send_close();
		send_cmd(make_cmd(srfu_pkg::OP_CLOSE, srfu_pkg::BANK_COUNT, 8'd0, '0, 1'b0));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed words: extremes, empty bank, nested restore, global write in a scope
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_COUNT, 8'd0,   '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_GLUE,  8'd255, '0, 1'b1));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_COUNT, 8'd0, 32'h7FFF_FFFF, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_GLUE, 8'd255, 32'h8000_0000, 1'b1));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_COUNT, 8'd0,   '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_GLUE,  8'd255, '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, BANK_NONE,  8'd5,   32'hFFFF_FFFF, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  BANK_NONE,  8'd5,   '0, 1'b0));
		send_close();
		send_cmd(make_cmd(srfu_pkg::OP_OPEN,  srfu_pkg::BANK_COUNT, 8'd0,   '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_DIM, 8'd128, 32'hFFFF_FFFF, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_DIM, 8'd128, 32'h0000_1234, 1'b1));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_DIM,   8'd128, '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_OPEN,  srfu_pkg::BANK_GLUE, 8'd17, 32'hFFFF_FFFF, 1'b1));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_COUNT, 8'd0,   32'd12345, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_DIM, 8'd128, 32'h5A5A_5A5A, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_COUNT, 8'd0,   '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_CLOSE, BANK_NONE,  8'd255, 32'hFFFF_FFFF, 1'b1));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_COUNT, 8'd0,   '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_DIM,   8'd128, '0, 1'b0));
		send_close();
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_DIM,   8'd128, '0, 1'b0));
		send_cmd(make_cmd(srfu_pkg::OP_OPEN,  BANK_NONE,  8'd255, 32'hFFFF_FFFF, 1'b1));
		send_close();
		send_cmd(make_cmd(srfu_pkg::OP_READ,  srfu_pkg::BANK_GLUE,  8'd255, '0, 1'b0));

		send_mixed(40);
		wait_drained();

		send_idle_pct = 62;
		send_mixed(40);
		wait_drained();

		send_idle_pct = 0;
		// nest to the full scope depth, then unwind everything
		while (sb.scope_top < SCOPE_DEPTH) begin
			send_cmd(make_cmd(srfu_pkg::OP_OPEN, 2'($urandom_range(3)), 8'($urandom_range(255)),
				$urandom, 1'($urandom_range(1))));
			if ($urandom_range(1) == 0)
				send_cmd(local_write());
		end
		repeat (2) send_cmd(make_cmd(srfu_pkg::OP_OPEN, srfu_pkg::BANK_COUNT, 8'd0, '0, 1'b0));
		while (sb.scope_top > 0) begin
			send_close();
			if ($urandom_range(2) == 0)
				send_cmd(make_cmd(srfu_pkg::OP_READ,
					2'($urandom_range(srfu_pkg::NUM_BANKS - 1)),
					8'($urandom_range(7)), '0, 1'b0));
		end
		send_close();

		// fill the undo stack until local writes are refused
		send_cmd(make_cmd(srfu_pkg::OP_OPEN, srfu_pkg::BANK_COUNT, 8'd0, '0, 1'b0));
		while (sb.undo_top < UNDO_DEPTH) send_cmd(local_write());
		repeat (3) send_cmd(local_write());
		send_cmd(make_cmd(srfu_pkg::OP_WRITE, srfu_pkg::BANK_DIM, 8'd3, $urandom, 1'b1));
		repeat (3) send_cmd(make_cmd(srfu_pkg::OP_READ,
			2'($urandom_range(srfu_pkg::NUM_BANKS - 1)), 8'($urandom_range(255)), '0, 1'b0));
		while (sb.scope_top > 0) send_close();
		send_cmd(make_cmd(srfu_pkg::OP_READ, srfu_pkg::BANK_DIM, 8'd3, '0, 1'b0));

		send_mixed(20);
		wait_drained();
		repeat (END_CYCLES) @(posedge clk);

		if (sb.pending_results.size() != 0)
			sb.report_mismatch("expected words left over");
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
